>>> rtl/gb5_pkg.sv
// ---------------------------------------------------------------------------
// gb5_pkg
// Types and constants shared by the 5x5 Gaussian blur block: kernel taps,
// reciprocal for the divide by 273, field widths and register indexes.
// ---------------------------------------------------------------------------
`default_nettype none

package gb5_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 13;
    localparam int IMG_W_W    = 11;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;
    localparam int LINES      = 4;
    localparam int LS_W       = LINES * PIX_W;
    localparam int ROWSUM_W   = 15;
    localparam int SUM_W      = 17;
    localparam int RECIP_W    = 18;
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam int RECIP_SHIFT = 26;
    localparam int Q_W        = PROD_W - RECIP_SHIFT;

    localparam logic [ROW_W-1:0]   MAX_HEIGHT = 13'd4096;
    localparam logic [RECIP_W-1:0] RECIP_273  = 18'd245821;
    localparam logic [Q_W-1:0]     PIX_MAX    = 9'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 4'd1;

    localparam logic [5:0] KERNEL [5][5] = '{
        '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
        '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
        '{6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
        '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
        '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
    };

    typedef logic [PIX_W-1:0]    t_pix;
    typedef logic [ROWSUM_W-1:0] t_rowsum;

    typedef struct packed {
        logic last_of_run;
        logic end_of_frame;
    } t_flags;

endpackage

`default_nettype wire

>>> rtl/gb5_pix_if.sv
// ---------------------------------------------------------------------------
// gb5_pix_if
// Source pixel channel: one raster position per request.
// ---------------------------------------------------------------------------
`default_nettype none

interface gb5_pix_if
    import gb5_pkg::*;
();
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] pixel;

    modport source (output valid, output kind, output pixel, input ready);
    modport sink   (input valid, input kind, input pixel, output ready);
endinterface

`default_nettype wire

>>> rtl/gb5_res_if.sv
// ---------------------------------------------------------------------------
// gb5_res_if
// Result channel: one blurred pixel per request, with run and frame marks.
// ---------------------------------------------------------------------------
`default_nettype none

interface gb5_res_if
    import gb5_pkg::*;
();
    logic       valid;
    logic       ready;
    t_pix       blurred;
    logic       last_of_run;
    logic       end_of_frame;

    modport source (output valid, output blurred, output last_of_run,
                    output end_of_frame, input ready);
    modport sink   (input valid, input blurred, input last_of_run,
                    input end_of_frame, output ready);
endinterface

`default_nettype wire

>>> rtl/gb5_cfg_if.sv
// ---------------------------------------------------------------------------
// gb5_cfg_if
// Register write channel: register index and write data per request.
// ---------------------------------------------------------------------------
`default_nettype none

interface gb5_cfg_if
    import gb5_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/gb5_ram.sv
// ---------------------------------------------------------------------------
// gb5_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds when no read is issued.
// ---------------------------------------------------------------------------
`default_nettype none

module gb5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

`default_nettype wire

>>> rtl/gaussian_blur_5x5.sv
// ---------------------------------------------------------------------------
// gaussian_blur_5x5
// 5x5 Gaussian blur (kernel sum 273) over a raster stream of 8-bit pixels.
//
// i_pix takes one raster position per request (kind 0 pixel, kind 1 flush);
// after the image the host sends two flush rows. o_res returns blurred
// pixels in raster order; the result for (y,x) leaves with the request at
// (y+2,x+2), and the last column of a row also releases the two remaining
// results of the row two above. last_of_run marks the final result of a
// request, end_of_frame the image's last pixel. i_cfg writes image_width
// (index 0) and image_height (index 1); a write restarts the frame.
// The line store is one MAX_WIDTH x 32 RAM, one word per column holding
// the four previous rows; each request reads its column and writes it
// back shifted.
// Throughput: one request per cycle while o_res accepts, except the last
// column of a row, which holds the window stage while it steps out the
// two extra results of the row two above. Each result passes the window,
// row sums, sum, reciprocal multiply and output register stages in order.
// A stalled o_res backs up the pipeline; i_pix is still taken while free
// stages remain. Reset clears counters, window and pipeline valids; RAM
// contents are never used before being written in the current frame.
// ---------------------------------------------------------------------------
`default_nettype none

module gaussian_blur_5x5
    import gb5_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gb5_pix_if.sink    i_pix,
    gb5_res_if.source  o_res,
    gb5_cfg_if.sink    i_cfg
);
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [IMG_W_W-1:0] MAX_W11 = IMG_W_W'(MAX_WIDTH);

    // configuration
    logic [IMG_W_W-1:0] r_image_width;
    logic [ROW_W-1:0]   r_image_height;
    logic [IMG_W_W-1:0] w_eff;
    logic [ROW_W-1:0]   h_eff;
    logic [ROW_W:0]     h_p1;
    logic [CW-1:0]      col_last;
    logic               cfg_wr;
    logic               cfg_hit;

    // raster position
    logic [CW-1:0]      r_col;
    logic [ROW_W-1:0]   r_row;
    logic               accept;
    logic               last_col;
    t_pix               in_val;
    logic [3:0]         in_rmask;

    // window stage
    logic               r_b_vld;
    logic [1:0]         r_b_k;
    t_pix               r_b_val;
    logic [CW-1:0]      r_b_col;
    logic               r_b_last_col;
    logic [3:0]         r_b_rmask;
    logic [2:0]         r_b_vcs;
    logic               r_b_row_ge2;
    logic               r_b_eof_row;
    t_pix               r_win [5][5];
    t_pix               n_win [5][5];
    t_pix               col_new [5];
    logic [2:0]         vc;
    logic [4:0]         cmask;
    logic               emit;
    logic               step_b;
    logic               b_k_last;
    logic               b_done;
    t_flags             b_flags;
    t_rowsum            rs [5];

    // line store
    logic               ram_we;
    logic               ram_re;
    logic [LS_W-1:0]    ram_wdata;
    logic [LS_W-1:0]    ram_rdata;

    // arithmetic pipeline
    logic               ld1, ld2, ld3, ld_out;
    logic               r_c1_vld, r_c2_vld, r_c3_vld, r_o_vld;
    t_rowsum            r_c1_rs [5];
    t_flags             r_c1_flags, r_c2_flags, r_c3_flags, r_o_flags;
    logic [SUM_W-1:0]   r_c2_sum;
    logic [PROD_W-1:0]  r_c3_prod;
    logic [Q_W-1:0]     quot;
    t_pix               r_o_blurred;

    // -----------------------------------------------------------------------
    // Configuration
    // -----------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;

    always_comb begin
        unique case (i_cfg.index)
            CFG_IMAGE_WIDTH:  cfg_hit = cfg_wr;
            CFG_IMAGE_HEIGHT: cfg_hit = cfg_wr;
            default:          cfg_hit = 1'b0;
        endcase
    end

    always_comb begin
        if (r_image_width == '0) begin
            w_eff = IMG_W_W'(1);
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            w_eff = MAX_W11;
        end else begin
            w_eff = r_image_width;
        end
        if (r_image_height == '0) begin
            h_eff = ROW_W'(1);
        end else if (r_image_height > MAX_HEIGHT) begin
            h_eff = MAX_HEIGHT;
        end else begin
            h_eff = r_image_height;
        end
    end

    assign col_last = CW'(w_eff - IMG_W_W'(1));
    assign h_p1     = (ROW_W+1)'(h_eff) + (ROW_W+1)'(1);

    // -----------------------------------------------------------------------
    // Request intake
    // -----------------------------------------------------------------------
    assign b_k_last    = r_b_last_col ? (r_b_k == 2'd2) : (r_b_k == 2'd0);
    assign step_b      = r_b_vld && ld1;
    assign b_done      = step_b && b_k_last;
    assign i_pix.ready = !r_b_vld || b_done;
    assign accept      = i_pix.valid && i_pix.ready;
    assign last_col    = (r_col == col_last);
    assign in_val      = (!i_pix.kind && (r_row < h_eff)) ? i_pix.pixel : '0;

    always_comb begin
        for (int i = 0; i < LINES; i++) begin
            in_rmask[i] = ((ROW_W+1)'(r_row) + (ROW_W+1)'(i) >= (ROW_W+1)'(4))
                && ((ROW_W+1)'(r_row) + (ROW_W+1)'(i) < (ROW_W+1)'(h_eff)
                    + (ROW_W+1)'(4));
        end
    end

    // -----------------------------------------------------------------------
    // Line store: word per column, byte i = row (y-4+i)
    // -----------------------------------------------------------------------
    assign ram_re    = accept;
    assign ram_we    = step_b && (r_b_k == 2'd0);
    assign ram_wdata = {r_b_val, ram_rdata[LS_W-1:PIX_W]};

    gb5_ram #(
        .WIDTH (LS_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_b_col),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // -----------------------------------------------------------------------
    // Window stage
    // -----------------------------------------------------------------------
    assign vc   = r_b_vcs + 3'(r_b_k);
    assign emit = r_b_row_ge2 && (vc >= 3'd2);

    always_comb begin
        b_flags.last_of_run  = b_k_last;
        b_flags.end_of_frame = r_b_last_col && (r_b_k == 2'd2) && r_b_eof_row;
        for (int j = 0; j < 5; j++) begin
            cmask[j] = (4'(vc) + 4'(j) >= 4'd4);
        end
        for (int i = 0; i < LINES; i++) begin
            col_new[i] = (r_b_k == 2'd0 && r_b_rmask[i])
                ? ram_rdata[i*PIX_W +: PIX_W] : '0;
        end
        col_new[4] = (r_b_k == 2'd0) ? r_b_val : '0;
        for (int i = 0; i < 5; i++) begin
            for (int j = 0; j < 4; j++) begin
                n_win[i][j] = r_win[i][j+1];
            end
            n_win[i][4] = col_new[i];
        end
        for (int i = 0; i < 5; i++) begin
            rs[i] = '0;
            for (int j = 0; j < 5; j++) begin
                if (cmask[j]) begin
                    rs[i] = rs[i] + ROWSUM_W'(KERNEL[i][j]) * ROWSUM_W'(n_win[i][j]);
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Pipeline flow
    // -----------------------------------------------------------------------
    assign ld_out = !r_o_vld || o_res.ready;
    assign ld3    = !r_c3_vld || ld_out;
    assign ld2    = !r_c2_vld || ld3;
    assign ld1    = !r_c1_vld || ld2;

    assign quot = r_c3_prod[PROD_W-1:RECIP_SHIFT];

    // -----------------------------------------------------------------------
    // Control registers
    // -----------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= IMG_W_W'(640);
            r_image_height <= ROW_W'(480);
            r_col          <= '0;
            r_row          <= '0;
            r_b_vld        <= 1'b0;
            r_b_k          <= '0;
            r_c1_vld       <= 1'b0;
            r_c2_vld       <= 1'b0;
            r_c3_vld       <= 1'b0;
            r_o_vld        <= 1'b0;
            for (int i = 0; i < 5; i++) begin
                for (int j = 0; j < 5; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else begin
            if (cfg_hit) begin
                if (i_cfg.index == CFG_IMAGE_WIDTH) begin
                    r_image_width <= i_cfg.data[IMG_W_W-1:0];
                end else begin
                    r_image_height <= i_cfg.data[ROW_W-1:0];
                end
                r_col <= '0;
                r_row <= '0;
                for (int i = 0; i < 5; i++) begin
                    for (int j = 0; j < 5; j++) begin
                        r_win[i][j] <= '0;
                    end
                end
            end else begin
                if (accept) begin
                    if (last_col) begin
                        r_col <= '0;
                        r_row <= ((ROW_W+1)'(r_row) >= h_p1) ? '0 : r_row + ROW_W'(1);
                    end else begin
                        r_col <= r_col + CW'(1);
                    end
                end
                if (step_b) begin
                    r_win <= n_win;
                end
            end

            if (accept) begin
                r_b_vld <= 1'b1;
                r_b_k   <= '0;
            end else if (b_done) begin
                r_b_vld <= 1'b0;
            end else if (step_b) begin
                r_b_k <= r_b_k + 2'd1;
            end

            if (ld1) begin
                r_c1_vld <= step_b && emit;
            end
            if (ld2) begin
                r_c2_vld <= r_c1_vld;
            end
            if (ld3) begin
                r_c3_vld <= r_c2_vld;
            end
            if (ld_out) begin
                r_o_vld <= r_c3_vld;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Payload registers
    // -----------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_val      <= in_val;
            r_b_col      <= r_col;
            r_b_last_col <= last_col;
            r_b_rmask    <= in_rmask;
            r_b_vcs      <= (32'(r_col) >= 4) ? 3'd4 : 3'(r_col);
            r_b_row_ge2  <= (r_row >= ROW_W'(2));
            r_b_eof_row  <= ((ROW_W+1)'(r_row) == h_p1);
        end
        if (ld1 && step_b) begin
            r_c1_rs    <= rs;
            r_c1_flags <= b_flags;
        end
        if (ld2 && r_c1_vld) begin
            r_c2_sum   <= SUM_W'(r_c1_rs[0]) + SUM_W'(r_c1_rs[1]) + SUM_W'(r_c1_rs[2])
                        + SUM_W'(r_c1_rs[3]) + SUM_W'(r_c1_rs[4]);
            r_c2_flags <= r_c1_flags;
        end
        if (ld3 && r_c2_vld) begin
            r_c3_prod  <= PROD_W'(r_c2_sum) * PROD_W'(RECIP_273);
            r_c3_flags <= r_c2_flags;
        end
        if (ld_out && r_c3_vld) begin
            r_o_blurred <= (quot > PIX_MAX) ? PIX_MAX[PIX_W-1:0] : quot[PIX_W-1:0];
            r_o_flags   <= r_c3_flags;
        end
    end

    assign o_res.valid        = r_o_vld;
    assign o_res.blurred      = r_o_blurred;
    assign o_res.last_of_run  = r_o_flags.last_of_run;
    assign o_res.end_of_frame = r_o_flags.end_of_frame;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    a_ram_no_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we && ram_re |-> (r_b_col != r_col))
        else $error("line store read and write hit the same column");

    a_tail_only_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_vld && (r_b_k != 2'd0) |-> r_b_last_col)
        else $error("row tail steps outside the last column");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ROW_W+1)'(r_row) <= h_p1)
        else $error("row counter past the flush rows");

    a_eof_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && r_o_flags.end_of_frame |-> r_o_flags.last_of_run)
        else $error("frame end not on the final result of a request");

endmodule

`default_nettype wire

>>> sim/gb5_blur_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// gb5_blur_checker
// Watches the pixel, result and register channels of the 5x5 blur. Keeps
// its own copy of the geometry, row store and window, works out the blurred
// pixels each accepted request releases and matches them in order against
// the results the block hands out.
// ---------------------------------------------------------------------------

module gb5_blur_checker
    import gb5_pkg::*;
#(
    parameter logic FLUSH_KIND = 1'b1
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gb5_pix_if        i_pix,
    gb5_res_if        i_res,
    gb5_cfg_if        i_cfg,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_results,
    output int        o_frames
);

    localparam int WIDTH_CAP   = 1024;
    localparam int HEIGHT_CAP  = 4096;
    localparam int TAP_TOTAL   = 273;
    localparam int PIX_CEIL    = 255;
    localparam int REPORT_CAP  = 40;
    localparam int GAUSS_TAP [5][5] = '{
        '{1,  4,  7,  4, 1},
        '{4, 16, 26, 16, 4},
        '{7, 26, 41, 26, 7},
        '{4, 16, 26, 16, 4},
        '{1,  4,  7,  4, 1}
    };

    typedef struct packed {
        t_pix blurred;
        logic last_of_run;
        logic end_of_frame;
    } t_blur_out;

    logic [IMG_W_W-1:0] width_reg;
    logic [ROW_W-1:0]   height_reg;
    t_pix               rows_mem [4][WIDTH_CAP];
    t_pix               win [5][5];
    int                 col_pos;
    int                 row_pos;
    t_blur_out          blur_due [$];
    int                 fails;
    int                 results;
    int                 frames;

    task automatic report_mismatch(input string msg);
        if (fails < REPORT_CAP) begin
            $display("%0t: blur mismatch: %s", $time, msg);
        end
        fails++;
    endtask

    task automatic clear_window();
        for (int i = 0; i < 5; i++) begin
            for (int j = 0; j < 5; j++) begin
                win[i][j] = '0;
            end
        end
    endtask

    task automatic shift_window();
        for (int i = 0; i < 5; i++) begin
            for (int j = 0; j < 4; j++) begin
                win[i][j] = win[i][j+1];
            end
        end
    endtask

    // vc: column of the newest window column; columns left of the image drop out
    function automatic t_pix window_sum(input int vc);
        int acc;
        acc = 0;
        for (int i = 0; i < 5; i++) begin
            for (int j = 0; j < 5; j++) begin
                if (vc + j >= 4) begin
                    acc += int'(win[i][j]) * GAUSS_TAP[i][j];
                end
            end
        end
        acc = acc / TAP_TOTAL;
        return (acc > PIX_CEIL) ? t_pix'(PIX_CEIL) : t_pix'(acc);
    endfunction

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        bit hit;
        hit = 1'b1;
        if (index == CFG_IMAGE_WIDTH) begin
            width_reg = data[IMG_W_W-1:0];
        end else if (index == CFG_IMAGE_HEIGHT) begin
            height_reg = data[ROW_W-1:0];
        end else begin
            hit = 1'b0;
        end
        if (hit) begin
            clear_window();
            col_pos = 0;
            row_pos = 0;
        end
    endtask

    task automatic blur_step(input logic kind, input t_pix pixel);
        int        w;
        int        h;
        int        r;
        int        c;
        int        kmax;
        int        n;
        t_pix      v;
        t_blur_out outs [3];
        w = (width_reg == 0) ? 1 : ((int'(width_reg) > WIDTH_CAP) ? WIDTH_CAP : int'(width_reg));
        h = (height_reg == 0) ? 1 :
            ((int'(height_reg) > HEIGHT_CAP) ? HEIGHT_CAP : int'(height_reg));
        r = row_pos;
        c = col_pos;
        if (c >= w) c = 0;
        if (r > h + 1) r = 0;
        v = (kind != FLUSH_KIND && r < h) ? pixel : '0;

        shift_window();
        for (int i = 0; i < 4; i++) begin
            win[i][4] = (r + i >= 4 && r + i - 4 < h) ? rows_mem[(r + i - 4) % 4][c] : '0;
        end
        win[4][4] = v;
        rows_mem[r % 4][c] = v;

        kmax = (c == w - 1) ? 2 : 0;
        n = 0;
        for (int k = 0; k <= kmax; k++) begin
            if (k > 0) begin
                shift_window();
                for (int i = 0; i < 5; i++) win[i][4] = '0;
            end
            if (r >= 2 && c + k >= 2) begin
                outs[n].blurred      = window_sum(c + k);
                outs[n].last_of_run  = 1'b0;
                outs[n].end_of_frame = (r == h + 1 && c + k - 2 == w - 1);
                n++;
            end
        end
        if (n > 0) outs[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++) blur_due.push_back(outs[i]);

        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h + 2) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    always @(posedge i_clk) begin
        t_blur_out want;
        if (!i_rst_n) begin
            width_reg  = 11'd640;
            height_reg = 13'd480;
            clear_window();
            col_pos = 0;
            row_pos = 0;
            blur_due.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                results++;
                if (blur_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result blurred %0d", i_res.blurred));
                end else begin
                    want = blur_due.pop_front();
                    if (want.end_of_frame) frames++;
                    if (i_res.blurred !== want.blurred ||
                        i_res.last_of_run !== want.last_of_run ||
                        i_res.end_of_frame !== want.end_of_frame) begin
                        report_mismatch($sformatf(
                            "blurred %0d/%0d last %b/%b eof %b/%b (got/want)",
                            i_res.blurred, want.blurred, i_res.last_of_run,
                            want.last_of_run, i_res.end_of_frame, want.end_of_frame));
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) apply_reg(i_cfg.index, i_cfg.data);
            if (i_pix.valid && i_pix.ready) blur_step(i_pix.kind, i_pix.pixel);
        end
        o_fail_count <= fails;
        o_pending    <= blur_due.size();
        o_results    <= results;
        o_frames     <= frames;
    end

endmodule

>>> sim/gaussian_blur_5x5_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// gaussian_blur_5x5_test
// Drives raster frames through the 5x5 blur: a directed frame with flush
// and ignored positions, clamped geometries, random frames of small size
// and a long output hold. The checker beside the block predicts and
// compares every result.
// ---------------------------------------------------------------------------

module gaussian_blur_5x5_test;
    import gb5_pkg::*;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'd15;

    localparam int WIDTH_CAP      = 1024;
    localparam int HEIGHT_CAP     = 4096;
    localparam int RANDOM_ITEMS   = 110;
    localparam int SETTLE_CYCLES  = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;
    int   src_idle_pct  = 0;
    int   sink_idle_pct = 0;
    bit   hold_req      = 1'b0;
    bit   hold_done     = 1'b0;
    int   requests_sent = 0;
    int   reg_writes    = 0;
    int   idle_cycles   = 0;
    int   frame_w;
    int   frame_h;
    int   fail_count;
    int   pending;
    int   results;
    int   frames;

    gb5_pix_if pix ();
    gb5_res_if res ();
    gb5_cfg_if cfg ();

    gaussian_blur_5x5 u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_res   (res),
        .i_cfg   (cfg)
    );

    gb5_blur_checker #(
        .FLUSH_KIND (KIND_FLUSH)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix),
        .i_res        (res),
        .i_cfg        (cfg),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results),
        .o_frames     (frames)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((pix.valid && pix.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                res.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            res.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    function automatic int eff_dim(input int value, input int cap);
        return (value == 0) ? 1 : ((value > cap) ? cap : value);
    endfunction

    task automatic send_item(input logic kind, input t_pix value);
        while ($urandom_range(99) < src_idle_pct) begin
            pix.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.kind  <= kind;
        pix.pixel <= value;
        do @(posedge i_clk); while (!pix.ready);
        requests_sent++;
    endtask

    task automatic send_frame(input int rows, input int noise_pct);
        logic kind;
        t_pix value;
        int   pick;
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < frame_w; c++) begin
                kind = (r < frame_h) ? KIND_PIXEL : KIND_FLUSH;
                if ($urandom_range(99) < noise_pct) kind = ~kind;
                pick = $urandom_range(9);
                value = (pick == 0) ? 8'd0 : ((pick == 1) ? 8'd255 : t_pix'($urandom_range(255)));
                send_item(kind, value);
            end
        end
    endtask

    // block must be idle: wait out results, then the tail of the pipeline
    task automatic settle();
        pix.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] w_data,
                             input logic [CFG_DATA_W-1:0] h_data, input bit poke_spare);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] dat [3];
        int                    n;
        idx[0] = CFG_IMAGE_WIDTH;
        dat[0] = w_data;
        idx[1] = CFG_IMAGE_HEIGHT;
        dat[1] = h_data;
        idx[2] = CFG_SPARE;
        dat[2] = CFG_DATA_W'($urandom);
        n = poke_spare ? 3 : 2;
        for (int i = 0; i < n; i++) begin
            cfg.valid <= 1'b1;
            cfg.index <= idx[i];
            cfg.data  <= dat[i];
            do @(posedge i_clk); while (!cfg.ready);
            reg_writes++;
        end
        cfg.valid <= 1'b0;
        frame_w = eff_dim(int'(w_data[IMG_W_W-1:0]), WIDTH_CAP);
        frame_h = eff_dim(int'(h_data), HEIGHT_CAP);
    endtask

    initial begin
        logic                  kind;
        t_pix                  value;
        int                    random_start;
        logic [CFG_DATA_W-1:0] w_data;
        logic [CFG_DATA_W-1:0] h_data;

        i_rst_n   <= 1'b0;
        pix.valid <= 1'b0;
        pix.kind  <= KIND_PIXEL;
        pix.pixel <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= CFG_IMAGE_WIDTH;
        cfg.data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct  = 6;
        sink_idle_pct = 82;

        configure(13'd3, 13'd3, 1'b0);
        for (int n = 0; n < 15; n++) begin
            kind  = (n < 9) ? KIND_PIXEL : KIND_FLUSH;
            value = 8'd255;
            if (n == 4) kind = KIND_FLUSH;   // flush inside the image reads as zero
            if (n == 10) kind = KIND_PIXEL;  // pixel in a flush row is dropped
            if (n == 7 || n == 8) value = 8'd0;
            send_item(kind, value);
        end
        settle();
        // zero geometry clamps to 1x1; spare index must leave the frame alone
        configure(13'd0, 13'd0, 1'b1);
        send_item(KIND_PIXEL, 8'd255);
        send_item(KIND_PIXEL, 8'd170);
        send_item(KIND_FLUSH, 8'd85);

        random_start = requests_sent;
        while (requests_sent - random_start < RANDOM_ITEMS) begin
            if (requests_sent - random_start >= RANDOM_ITEMS / 2) begin
                src_idle_pct  = 82;
                sink_idle_pct = 6;
            end
            settle();
            w_data = CFG_DATA_W'($urandom_range(12)) |
                     (CFG_DATA_W'($urandom_range(3)) << IMG_W_W);
            h_data = CFG_DATA_W'($urandom_range(6));
            configure(w_data, h_data, $urandom_range(7) == 0);
            if ($urandom_range(5) == 0) begin
                send_frame($urandom_range(1, frame_h + 1), 5);  // cut short, next write restarts
            end else begin
                repeat ($urandom_range(1, 2)) send_frame(frame_h + 2, 5);
            end
        end

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        settle();
        configure(13'd12, 13'd4, 1'b0);
        hold_req <= 1'b1;
        send_frame(frame_h + 2, 5);
        settle();

        $display("%0d pixel requests, %0d register writes, %0d blurred pixels, %0d frames",
                 requests_sent, reg_writes, results, frames);
        $display("geometries 1x1 to 12x6, flush noise, cut frames, long output hold");
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> gaussian_blur_5x5.f
rtl/gb5_pkg.sv
rtl/gb5_pix_if.sv
rtl/gb5_res_if.sv
rtl/gb5_cfg_if.sv
rtl/gb5_ram.sv
rtl/gaussian_blur_5x5.sv
sim/gb5_blur_checker.sv
sim/gaussian_blur_5x5_test.sv
